// ===== rtl/pts_pkg.sv =====
// Package for the priority task scheduler: word types, operation, status and
// task state codes, and the record held per task slot.
// No dependencies.
package pts_pkg;

	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_START   = 3'd1;
	localparam logic [2:0] OP_END     = 3'd2;
	localparam logic [2:0] OP_SLEEP   = 3'd3;
	localparam logic [2:0] OP_SUSPEND = 3'd4;
	localparam logic [2:0] OP_RESUME  = 3'd5;
	localparam logic [2:0] OP_YIELD   = 3'd6;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_REJECT   = 2'd1;
	localparam logic [1:0] STAT_UNLINKED = 2'd2;

	localparam logic [1:0] TS_READY     = 2'd0;
	localparam logic [1:0] TS_SLEEPING  = 2'd1;
	localparam logic [1:0] TS_SUSPENDED = 2'd2;

	typedef struct packed {
		logic [2:0]  operation;
		logic [3:0]  slot;
		logic [15:0] priority_req;
		logic [31:0] sleep_ticks;
	} pts_in_t;

	typedef struct packed {
		logic [3:0] running_slot;
		logic       switch_request;
		logic       none_ready;
		logic [1:0] status;
	} pts_out_t;

	// Per-slot record kept in the slot memory.
	typedef struct packed {
		logic [1:0]  tstate;
		logic [15:0] prio;
		logic [63:0] wake_time;
	} pts_entry_t;

	localparam pts_entry_t ENTRY_RESET = '{tstate: TS_SUSPENDED, prio: 16'd0, wake_time: 64'd0};

	// Verdict of the slot evaluation unit for one visited slot.
	typedef struct packed {
		logic wake;
		logic pick;
	} pts_eval_t;

endpackage

// ===== rtl/priority_task_scheduler_core.sv =====
// Top level of the priority task scheduler: operation sequencer, scheduling
// pass and output register. Depends on pts_pkg, pts_ram and pts_eval.
//
// The scheduler keeps TASK_SLOTS task slots and takes one operation word at a
// time on the input channel; every word gives exactly one result word. The
// per-slot records (state, priority, wake time) live in one RAM with a single
// read port, so a scheduling pass reads one slot per cycle, starting at the
// slot after the running one, and a shared evaluation unit judges each slot as
// its data arrives. An operation without a pass (such as start, resume, a rejected
// start, an end of an unlinked slot) goes from the operation state straight to
// the done state; one with a pass goes through the pass state first, which ends
// early in first-ready mode when a ready slot turns up. The input is not ready
// while an operation is in progress. A finished result sits in an output
// register, so the next word is accepted while it waits; a result that finds the
// register still full holds the block until the receiver takes the earlier word.
// Link flags and written flags are flip-flops cleared by reset, so no memory
// clearing pass is needed after reset. first_ready_mode is written through
// cfg_we/cfg_wdata.
module priority_task_scheduler_core #(
	parameter int TASK_SLOTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pts_pkg::pts_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pts_pkg::pts_out_t out_data,
	input  logic              cfg_we,
	input  logic              cfg_wdata
);
	import pts_pkg::*;

	localparam int SLOT_W = $clog2(TASK_SLOTS);
	localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
	localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TASK_SLOTS - 1);
	localparam logic [CNT_W-1:0]  SLOT_COUNT = CNT_W'(TASK_SLOTS);
	localparam logic [CNT_W-1:0]  LAST_COUNT = CNT_W'(TASK_SLOTS - 1);

	typedef enum logic [1:0] {S_IDLE, S_OP, S_PASS, S_DONE} state_t;

	// Slot index after a given one, wrapping at the last slot.
	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] idx);
		logic [SLOT_W-1:0] nxt;
		nxt = (idx == LAST_SLOT) ? '0 : idx + 1'b1;
		return nxt;
	endfunction

	state_t                state_q;
	logic                  mode_q;
	logic [63:0]           uptime_q;
	logic [SLOT_W-1:0]     cur_q;
	logic [TASK_SLOTS-1:0] linked_q;
	logic [TASK_SLOTS-1:0] written_q;
	pts_in_t               item_q;
	logic [SLOT_W-1:0]     rd_idx_q;
	logic [CNT_W-1:0]      iss_q;
	logic [CNT_W-1:0]      ev_cnt_q;
	logic                  ev_v_s1;
	logic [SLOT_W-1:0]     ev_idx_s1;
	logic [SLOT_W-1:0]     best_q;
	logic [15:0]           best_prio_q;
	logic                  found_q;
	logic                  res_sw_q;
	logic                  res_none_q;
	logic [1:0]            status_q;
	pts_out_t              out_q;
	logic                  out_valid_q;

	logic              slot_ok_in;
	logic [SLOT_W-1:0] sidx_in;
	logic              slot_ok;
	logic [SLOT_W-1:0] sidx;
	pts_entry_t        entry_raw;
	pts_entry_t        entry;
	logic [SLOT_W-1:0] rd_owner;
	pts_eval_t         verdict;

	logic       op_we;
	pts_entry_t op_wdata;
	logic       op_pass;
	logic [1:0] op_status;
	logic       link_set;
	logic       link_clr;

	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	pts_entry_t        ram_wdata;
	logic [SLOT_W-1:0] ram_raddr;

	logic              issue;
	logic              pass_end;
	logic              found_now;
	logic [SLOT_W-1:0] best_now;
	logic              out_load;

	// A slot number at or above TASK_SLOTS addresses no slot; it maps to slot
	// zero and every operation on it is guarded by the range flag.
	assign slot_ok_in = 32'(in_data.slot) < 32'(TASK_SLOTS);
	assign sidx_in    = slot_ok_in ? SLOT_W'(in_data.slot) : '0;
	assign slot_ok    = 32'(item_q.slot) < 32'(TASK_SLOTS);
	assign sidx       = slot_ok ? SLOT_W'(item_q.slot) : '0;

	// The read data belongs to the operation's slot while the operation is
	// applied, and to the slot in the evaluation stage during a pass. A slot
	// never written since reset reads as its reset record.
	assign rd_owner = (state_q == S_PASS) ? ev_idx_s1 : sidx;
	assign entry    = written_q[rd_owner] ? entry_raw : ENTRY_RESET;

	pts_ram #(
		.WIDTH($bits(pts_entry_t)),
		.DEPTH(TASK_SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(entry_raw)
	);

	pts_eval u_eval (
		.entry    (entry),
		.linked   (linked_q[ev_idx_s1]),
		.uptime   (uptime_q),
		.best_prio(best_prio_q),
		.verdict  (verdict)
	);

	// Operation decode, applied in the cycle after the slot record is read.
	always_comb begin
		op_we     = 1'b0;
		op_wdata  = entry;
		op_pass   = 1'b0;
		op_status = STAT_OK;
		link_set  = 1'b0;
		link_clr  = 1'b0;
		case (item_q.operation)
			OP_TICK: begin
				op_pass = 1'b1;
			end
			OP_START: begin
				if (!slot_ok || (item_q.priority_req == 16'd0) || linked_q[sidx]) begin
					op_status = STAT_REJECT;
				end else begin
					op_we              = 1'b1;
					op_wdata.tstate    = TS_READY;
					op_wdata.prio      = item_q.priority_req;
					op_wdata.wake_time = 64'd0;
					link_set           = 1'b1;
				end
			end
			OP_END: begin
				if (!slot_ok || !linked_q[sidx]) begin
					op_status = STAT_UNLINKED;
				end else begin
					link_clr = 1'b1;
					op_pass  = 1'b1;
				end
			end
			OP_SLEEP: begin
				if (slot_ok) begin
					op_we              = 1'b1;
					op_wdata.tstate    = TS_SLEEPING;
					op_wdata.wake_time = uptime_q + {32'd0, item_q.sleep_ticks};
					op_pass            = 1'b1;
				end
			end
			OP_SUSPEND: begin
				if (slot_ok && (entry.tstate != TS_SUSPENDED)) begin
					op_we           = 1'b1;
					op_wdata.tstate = TS_SUSPENDED;
					op_pass         = 1'b1;
				end
			end
			OP_RESUME: begin
				if (slot_ok) begin
					op_we           = 1'b1;
					op_wdata.tstate = TS_READY;
				end
			end
			OP_YIELD: begin
				op_pass = 1'b1;
			end
			default: begin
				op_pass = 1'b0;
			end
		endcase
	end

	// Pass control: one read is issued per cycle until every slot has been
	// requested; the evaluation stage takes the read data in the cycle after
	// the read. In first-ready mode the pass ends at the first pick, so later
	// sleepers are left as they are.
	assign issue    = (state_q == S_PASS) && (iss_q != SLOT_COUNT);
	assign pass_end = (state_q == S_PASS) && ev_v_s1
		&& ((ev_cnt_q == LAST_COUNT) || (verdict.pick && mode_q));
	assign found_now = found_q || verdict.pick;
	assign best_now  = verdict.pick ? ev_idx_s1 : best_q;

	// The finished result moves into the output register once it is free or
	// being emptied at this edge.
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Memory port selection. A waking slot is written back as ready; the
	// evaluation stage never touches the slot being read, since a pass
	// visits each slot once.
	always_comb begin
		if (state_q == S_PASS) begin
			ram_we    = ev_v_s1 && verdict.wake;
			ram_waddr = ev_idx_s1;
			ram_wdata = '{tstate: TS_READY, prio: entry.prio, wake_time: entry.wake_time};
		end else begin
			ram_we    = (state_q == S_OP) && op_we;
			ram_waddr = sidx;
			ram_wdata = op_wdata;
		end
		ram_raddr = (state_q == S_IDLE) ? sidx_in : rd_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= 1'b0;
			uptime_q    <= 64'd0;
			cur_q       <= '0;
			linked_q    <= '0;
			written_q   <= '0;
			ev_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (ram_we) begin
				written_q[ram_waddr] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			ev_v_s1   <= issue && !pass_end;
			ev_idx_s1 <= rd_idx_q;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						state_q <= S_OP;
					end
				end
				S_OP: begin
					status_q   <= op_status;
					res_sw_q   <= 1'b0;
					res_none_q <= 1'b0;
					if (link_set) begin
						linked_q[sidx] <= 1'b1;
					end
					if (link_clr) begin
						linked_q[sidx] <= 1'b0;
					end
					if (item_q.operation == OP_TICK) begin
						uptime_q <= uptime_q + 64'd1;
					end
					if (op_pass) begin
						rd_idx_q    <= next_slot(cur_q);
						iss_q       <= '0;
						ev_cnt_q    <= '0;
						best_prio_q <= 16'd0;
						found_q     <= 1'b0;
						state_q     <= S_PASS;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_PASS: begin
					if (issue) begin
						rd_idx_q <= next_slot(rd_idx_q);
						iss_q    <= iss_q + 1'b1;
					end
					if (ev_v_s1) begin
						ev_cnt_q <= ev_cnt_q + 1'b1;
						if (verdict.pick) begin
							best_q      <= ev_idx_s1;
							best_prio_q <= entry.prio;
							found_q     <= 1'b1;
						end
					end
					if (pass_end) begin
						state_q <= S_DONE;
						if (found_now) begin
							cur_q      <= best_now;
							res_sw_q   <= (best_now != cur_q);
							res_none_q <= 1'b0;
						end else begin
							res_none_q <= 1'b1;
						end
					end
				end
				S_DONE: begin
					if (out_load) begin
						out_q.running_slot   <= 4'(cur_q);
						out_q.switch_request <= res_sw_q;
						out_q.none_ready     <= res_none_q;
						out_q.status         <= status_q;
						state_q              <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The evaluation stage only carries a slot while a pass is running.
	assert property (@(posedge clk) disable iff (!arst_n)
		ev_v_s1 |-> (state_q == S_PASS))
		else $error("evaluation stage active outside a pass");

	// A pass never changes a slot record except to wake it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && (state_q == S_PASS)) |-> (ram_wdata.tstate == TS_READY))
		else $error("pass wrote a state other than ready");

	// A word reporting no ready slot never requests a switch.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.none_ready && out_q.switch_request))
		else $error("switch requested with no ready slot");

	// The running slot always addresses an existing slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_q) < 32'(TASK_SLOTS))
		else $error("running slot out of range");

endmodule

// ===== rtl/pts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/pts_eval.sv =====
// Slot evaluation unit: decides for one visited slot whether it wakes and
// whether it beats the best candidate so far. Depends on pts_pkg.
module pts_eval (
	input  pts_pkg::pts_entry_t entry,
	input  logic                linked,
	input  logic [63:0]         uptime,
	input  logic [15:0]         best_prio,
	output pts_pkg::pts_eval_t  verdict
);
	import pts_pkg::*;

	logic wake;
	logic ready;

	// A sleeping slot wakes once its wake time is not after uptime.
	assign wake  = linked && (entry.tstate == TS_SLEEPING) && (uptime >= entry.wake_time);
	assign ready = linked && ((entry.tstate == TS_READY) || wake);

	assign verdict.wake = wake;
	assign verdict.pick = ready && (entry.prio > best_prio);

endmodule

// ===== sim/schedule_checker.sv =====
`timescale 1ns / 100ps
// Checker for the priority task scheduler: predicts every result word from the accepted
// operation words and compares it with what the block returns. Depends on pts_pkg.
module schedule_checker #(
	parameter int TASK_SLOTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  pts_pkg::pts_in_t  in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  pts_pkg::pts_out_t out_data,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	output int                pending,
	output int                errors
);
	import pts_pkg::*;

	// Private copy of the scheduler state.
	logic        first_ready;
	logic [63:0] uptime_ms;
	logic [3:0]  running;
	logic        linked [TASK_SLOTS];
	logic [1:0]  tstate [TASK_SLOTS];
	logic [15:0] prio [TASK_SLOTS];
	logic [63:0] wake_at [TASK_SLOTS];

	pts_out_t expected_results[$];

	initial errors = 0;
	initial pending = 0;

	task automatic clear_schedule();
		first_ready = 1'b0;
		uptime_ms = '0;
		running = '0;
		for (int i = 0; i < TASK_SLOTS; i++) begin
			linked[i] = 1'b0;
			tstate[i] = TS_SUSPENDED;
			prio[i] = '0;
			wake_at[i] = '0;
		end
	endtask

	// One pass over all slots, starting after the running one. Sleepers that are due wake
	// up as they are visited; in first-ready mode the pass stops at the first ready slot.
	task automatic schedule_pass(output logic sw, output logic nr);
		int s;
		logic [3:0] best;
		logic [15:0] best_prio;
		logic found;
		best = '0;
		best_prio = '0;
		found = 1'b0;
		for (int i = 1; i <= TASK_SLOTS; i++) begin
			s = (int'(running) + i) % TASK_SLOTS;
			if (!linked[s])
				continue;
			if (tstate[s] == TS_SLEEPING && uptime_ms >= wake_at[s])
				tstate[s] = TS_READY;
			if (tstate[s] == TS_READY && prio[s] > best_prio) begin
				best_prio = prio[s];
				best = s[3:0];
				found = 1'b1;
				if (first_ready)
					break;
			end
		end
		if (!found) begin
			sw = 1'b0;
			nr = 1'b1;
		end else begin
			nr = 1'b0;
			sw = (best != running);
			running = best;
		end
	endtask

	// A slot number at or above TASK_SLOTS is treated as an unlinked slot that is not
	// there: starts are rejected, ends report it unlinked, and the rest do nothing.
	task automatic predict_schedule(input pts_in_t w, output pts_out_t r);
		logic do_pass;
		logic sw;
		logic nr;
		logic valid;
		int sidx;
		do_pass = 1'b0;
		sw = 1'b0;
		nr = 1'b0;
		valid = int'(w.slot) < TASK_SLOTS;
		sidx = valid ? int'(w.slot) : 0;
		r.status = STAT_OK;
		case (w.operation)
			OP_TICK: begin
				uptime_ms = uptime_ms + 64'd1;
				do_pass = 1'b1;
			end
			OP_START: begin
				if (!valid || w.priority_req == '0 || linked[sidx]) begin
					r.status = STAT_REJECT;
				end else begin
					linked[sidx] = 1'b1;
					tstate[sidx] = TS_READY;
					prio[sidx] = w.priority_req;
					wake_at[sidx] = '0;
				end
			end
			OP_END: begin
				if (!valid || !linked[sidx]) begin
					r.status = STAT_UNLINKED;
				end else begin
					linked[sidx] = 1'b0;
					do_pass = 1'b1;
				end
			end
			OP_SLEEP: begin
				if (valid) begin
					wake_at[sidx] = uptime_ms + {32'd0, w.sleep_ticks};
					tstate[sidx] = TS_SLEEPING;
					do_pass = 1'b1;
				end
			end
			OP_SUSPEND: begin
				if (valid && tstate[sidx] != TS_SUSPENDED) begin
					tstate[sidx] = TS_SUSPENDED;
					do_pass = 1'b1;
				end
			end
			OP_RESUME: begin
				if (valid)
					tstate[sidx] = TS_READY;
			end
			OP_YIELD: begin
				do_pass = 1'b1;
			end
			default: begin
			end
		endcase
		if (do_pass)
			schedule_pass(sw, nr);
		r.running_slot = running;
		r.switch_request = sw;
		r.none_ready = nr;
	endtask

	task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
		$display("ERROR at %0t: %s got %0h expected %0h", $time, field, got, want);
		errors = errors + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pts_out_t want;
		pts_out_t next;
		if (!arst_n) begin
			clear_schedule();
			expected_results.delete();
			pending = 0;
		end else begin
			// Results are retired before new words are predicted: a word accepted at this
			// edge cannot have its result at the same edge.
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report("result word with nothing expected", 32'(out_data), 32'd0);
				end else begin
					want = expected_results.pop_front();
					if (out_data.running_slot !== want.running_slot)
						report("running_slot", 32'(out_data.running_slot),
							32'(want.running_slot));
					if (out_data.switch_request !== want.switch_request)
						report("switch_request", 32'(out_data.switch_request),
							32'(want.switch_request));
					if (out_data.none_ready !== want.none_ready)
						report("none_ready", 32'(out_data.none_ready),
							32'(want.none_ready));
					if (out_data.status !== want.status)
						report("status", 32'(out_data.status), 32'(want.status));
				end
			end
			if (in_valid && in_ready) begin
				predict_schedule(in_data, next);
				expected_results.insert(expected_results.size(), next);
			end
			if (cfg_we)
				first_ready = cfg_wdata;
			pending = expected_results.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Top of the priority task scheduler testbench: clock, reset, operation stimulus,
// result back-pressure and verdict. Depends on pts_pkg, schedule_checker and the block.
module testbench;
	import pts_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 11;
	localparam int TASK_SLOTS   = 16;
	// The cycle limit for the run leaves a wide margin.
	localparam int CYCLE_LIMIT  = 500000;
	localparam int WORDS_PER_RUN = 212;
	// The operation code that the block has to ignore.
	localparam logic [2:0] OP_UNDEFINED = 3'd7;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	pts_in_t   in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	pts_out_t  out_data;
	logic      cfg_we = 1'b0;
	logic      cfg_wdata = 1'b0;

	int pending;
	int errors;
	int cycle_count = 0;
	int send_idle = 0;
	int recv_stall = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	priority_task_scheduler_core #(
		.TASK_SLOTS(TASK_SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	schedule_checker #(
		.TASK_SLOTS(TASK_SLOTS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.pending(pending),
		.errors(errors)
	);

	// The receiver stalls on a random share of cycles, set per phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	// Hard stop in case the block hangs or drops a result word.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d result words outstanding",
				cycle_count, pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic pts_in_t make_word(input logic [2:0] op, input logic [3:0] slot,
		input logic [15:0] prio, input logic [31:0] ticks);
		pts_in_t w;
		w.operation = op;
		w.slot = slot;
		w.priority_req = prio;
		w.sleep_ticks = ticks;
		return w;
	endfunction

	// Random operation word. Ticks and starts dominate so that slots get linked and
	// sleepers come due; slots lean toward a few low numbers so that operations keep
	// hitting slots that are actually linked. Small priorities make ties common.
	function automatic pts_in_t random_word();
		pts_in_t w;
		int r;
		r = $urandom_range(99);
		if (r < 28)
			w.operation = OP_TICK;
		else if (r < 44)
			w.operation = OP_START;
		else if (r < 52)
			w.operation = OP_END;
		else if (r < 64)
			w.operation = OP_SLEEP;
		else if (r < 74)
			w.operation = OP_SUSPEND;
		else if (r < 86)
			w.operation = OP_RESUME;
		else if (r < 97)
			w.operation = OP_YIELD;
		else
			w.operation = OP_UNDEFINED;
		if ($urandom_range(99) < 60)
			w.slot = 4'($urandom_range(5));
		else
			w.slot = 4'($urandom_range(15));
		r = $urandom_range(99);
		if (r < 10)
			w.priority_req = '0;
		else if (r < 50)
			w.priority_req = 16'($urandom_range(4, 1));
		else if (r < 60)
			w.priority_req = 16'hFFFF;
		else
			w.priority_req = 16'($urandom_range(65535));
		r = $urandom_range(99);
		if (r < 60)
			w.sleep_ticks = 32'($urandom_range(6));
		else if (r < 80)
			w.sleep_ticks = 32'($urandom_range(63));
		else if (r < 95)
			w.sleep_ticks = $urandom;
		else
			w.sleep_ticks = 32'hFFFF_FFFF;
		return w;
	endfunction

	// Offers one operation word after an optional random gap and holds it until the
	// block takes it. Valid stays high into the next word when there is no gap.
	task automatic send_word(input pts_in_t w);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Stops sending and waits until every predicted result word has come back. The
	// count is sampled on the falling edge, away from the checker's updates.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// The mode register is only written while the block has nothing in flight.
	task automatic write_mode(input logic first_ready);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_wdata <= first_ready;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int idle_of_phase [4];
		int stall_of_phase [4];
		idle_of_phase = '{0, 58, 0, 27};
		stall_of_phase = '{0, 0, 58, 27};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, highest-priority mode, no idling.
		write_mode(1'b0);
		// Nothing is linked yet: a pass finds no ready task.
		send_word(make_word(OP_TICK, 4'd0, 16'd0, 32'd0));
		send_word(make_word(OP_YIELD, 4'd0, 16'd0, 32'd0));
		// The undefined operation must leave everything alone.
		send_word(make_word(OP_UNDEFINED, 4'd9, 16'hFFFF, 32'hFFFF_FFFF));
		// A start with priority zero is rejected.
		send_word(make_word(OP_START, 4'd5, 16'd0, 32'd0));
		send_word(make_word(OP_START, 4'd0, 16'hFFFF, 32'd0));
		send_word(make_word(OP_START, 4'd15, 16'd1, 32'd0));
		// A start on a slot that is already linked is rejected.
		send_word(make_word(OP_START, 4'd15, 16'd7, 32'd0));
		send_word(make_word(OP_TICK, 4'd0, 16'd0, 32'd0));
		// Equal top priorities: the first one after the running slot wins.
		send_word(make_word(OP_START, 4'd3, 16'hFFFF, 32'd0));
		send_word(make_word(OP_YIELD, 4'd0, 16'd0, 32'd0));
		send_word(make_word(OP_SLEEP, 4'd0, 16'd0, 32'd2));
		send_word(make_word(OP_TICK, 4'd0, 16'd0, 32'd0));
		send_word(make_word(OP_TICK, 4'd0, 16'd0, 32'd0));
		send_word(make_word(OP_SUSPEND, 4'd3, 16'd0, 32'd0));
		// Suspending a slot that is already suspended does nothing.
		send_word(make_word(OP_SUSPEND, 4'd3, 16'd0, 32'd0));
		send_word(make_word(OP_RESUME, 4'd3, 16'd0, 32'd0));
		send_word(make_word(OP_END, 4'd3, 16'd0, 32'd0));
		// Ending a slot that is not linked gives the unlinked status and no pass.
		send_word(make_word(OP_END, 4'd3, 16'd0, 32'd0));
		// On an unlinked slot, sleep sets its state and runs a pass; resume sets its state.
		send_word(make_word(OP_SLEEP, 4'd7, 16'd0, 32'hFFFF_FFFF));
		send_word(make_word(OP_RESUME, 4'd7, 16'd0, 32'd0));
		send_word(make_word(OP_SLEEP, 4'd15, 16'd0, 32'd0));
		send_word(make_word(OP_END, 4'd0, 16'd0, 32'd0));
		send_word(make_word(OP_END, 4'd15, 16'd0, 32'd0));
		send_word(make_word(OP_YIELD, 4'd0, 16'd0, 32'd0));

		// Random part: each idling phase runs once in each scheduling mode.
		for (int ph = 0; ph < 4; ph++) begin
			for (int m = 0; m < 2; m++) begin
				send_idle = idle_of_phase[ph];
				recv_stall <= stall_of_phase[ph];
				write_mode(m[0]);
				repeat (WORDS_PER_RUN) begin
					// Now and then the sender holds off until the block has drained.
					if ($urandom_range(149) == 0)
						wait_for_results();
					send_word(random_word());
				end
			end
		end

		wait_for_results();
		// Room for any stray result word after the last expected one.
		repeat (3 * TASK_SLOTS) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
